### rtl/sgps_pkg.sv
// Shared types and constants for the sky gradient pixel shader.
`timescale 1ns / 1ps

package sgps_pkg;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_CORNER = 2'd0,
    CFG_HORIZ  = 2'd1,
    CFG_VERT   = 2'd2
  } cfg_idx_t;

  // Pipeline stage numbering.
  localparam int SQ_STAGES  = 8;
  localparam int SQ_PER     = 4;
  localparam int DIV_STAGES = 5;
  localparam int DIV_PER    = 4;
  localparam int DIV_STEPS  = 17;
  localparam int SIDE_FIRST = 3;
  localparam int ST_SPAN    = 4;
  localparam int ST_DIR     = 5;
  localparam int ST_SQR     = 6;
  localparam int ST_SUM     = 7;
  localparam int ST_NUM     = ST_SUM + SQ_STAGES + 1;
  localparam int ST_K       = ST_NUM + DIV_STAGES + 1;
  localparam int ST_T       = ST_K + 1;
  localparam int ST_OUT     = ST_T + 1;
  localparam int NST        = ST_OUT + 1;

  // Colour arithmetic constants.
  localparam logic [14:0] C_GAIN   = 15'd25599;
  localparam logic [12:0] C_RECIP_R = 13'd5243;
  localparam logic [18:0] C_RECIP_G = 19'd268436;
  localparam logic [7:0]  C_BORDER_B = 8'd51;

  // Side data that follows every word to the output.
  typedef struct packed {
    logic        border;
    logic [23:0] bcolor;
  } side_t;

  // Square root iteration state.
  typedef struct packed {
    logic [31:0]        rad;
    logic [34:0]        rem;
    logic [31:0]        root;
    logic signed [15:0] dy;
  } sq_t;

  // Division iteration state.
  typedef struct packed {
    logic [34:0] r;
    logic [16:0] q;
    logic [32:0] d2;
    logic        nz;
  } dv_t;

endpackage

### rtl/sky_gradient_pixel_shader.sv
// Top level of the sky gradient pixel shader pipeline.
`timescale 1ns / 1ps

// Turns a pixel coordinate into a packed RRGGBB colour, one word per clock.
// The input channel carries pixel_col and pixel_row; a word is taken when
// in_valid is high and in_stall is low. The result channel carries
// pixel_color and in_border under out_valid and out_stall.
// Border pixels get a coordinate gradient; the rest get a sky shade from the
// normalised view ray, set up through the three view vector registers.
// Throughput is one word per clock while out_stall is low; the 25 register
// stages (constant divides, span products, a 32-step square root over eight
// stages and a 17-step divider over five) each take a new word every cycle
// unless a stall holds them. When the receiver stalls, words move up into
// empty stages until the pipeline is full, and only then is in_stall raised;
// nothing is dropped. Reset empties the pipeline and clears the three view
// registers to zero. Configuration must be written through cfg_we, cfg_index
// and cfg_wdata only while idle, by the user; the block does not enforce it.
module sky_gradient_pixel_shader
  import sgps_pkg::*;
#(
  parameter int IMG_WIDTH    = 1024,
  parameter int IMG_HEIGHT   = 512,
  parameter int BORDER_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [11:0] in_pixel_col,
  input  logic [11:0] in_pixel_row,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [23:0] out_pixel_color,
  output logic        out_in_border,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_wdata
);

  localparam int MU     = (2 ** 28) / IMG_WIDTH;
  localparam int MV     = (2 ** 28) / IMG_HEIGHT;
  localparam int BR_DIV = 100 * IMG_WIDTH;
  localparam int BG_DIV = 100 * IMG_HEIGHT;
  localparam int MBR    = (4096 * 25599) / BR_DIV;
  localparam int MBG    = (4096 * 25599) / BG_DIV;

  localparam logic [24:0] MU_C  = 25'(MU);
  localparam logic [24:0] MV_C  = 25'(MV);
  localparam logic [15:0] MBR_C = 16'(MBR);
  localparam logic [15:0] MBG_C = 16'(MBG);
  localparam logic signed [13:0] W_S    = 14'(IMG_WIDTH);
  localparam logic signed [13:0] H_S    = 14'(IMG_HEIGHT);
  localparam logic signed [13:0] BW_S   = 14'(BORDER_WIDTH);
  localparam logic signed [13:0] W_LO_S = 14'(IMG_WIDTH - BORDER_WIDTH);
  localparam logic signed [13:0] H_LO_S = 14'(IMG_HEIGHT - BORDER_WIDTH);

  // View registers.
  logic [47:0] cor_r, hor_r, ver_r;

  // Handshake state.
  logic [NST-1:0] vld_r;
  logic [NST-1:0] en;

  // Stage 0: reciprocal products.
  logic [11:0] col_a_r, row_a_r;
  logic        bord_a_r;
  logic [36:0] mu_a_r, mv_a_r;
  logic [27:0] mr_a_r, mg_a_r;
  logic        bord_nxt;
  logic signed [13:0] col_s, row_s;

  // Stage 1: first quotient estimates.
  logic [11:0] col_b_r, row_b_r;
  logic        bord_b_r;
  logic [23:0] u0_b_r, v0_b_r;
  logic [15:0] r0_b_r, g0_b_r;

  // Stage 2: back products for the remainder check.
  logic [11:0] col_c_r, row_c_r;
  logic        bord_c_r;
  logic [23:0] u0_c_r, v0_c_r;
  logic [15:0] r0_c_r, g0_c_r;
  logic [27:0] uw_c_r, vw_c_r;
  logic [26:0] rw_c_r, gw_c_r;

  // Stage 3: corrected fractions and border colour.
  logic [23:0] u16_r, v16_r, u16_nxt, v16_nxt;
  side_t       side_r [SIDE_FIRST:ST_T];
  side_t       side_nxt;

  // Stages 4 to 7: ray direction and squared length.
  logic signed [40:0] ph_r [3];
  logic signed [40:0] pv_r [3];
  logic signed [40:0] ph_nxt [3];
  logic signed [40:0] pv_nxt [3];
  logic signed [15:0] d_r [3];
  logic signed [15:0] d_nxt [3];
  logic [30:0]        sq_r [3];
  logic [30:0]        sq_nxt [3];
  logic signed [15:0] dy_r;

  // Square root and divider iterations.
  sq_t sqs_r [SQ_STAGES+1];
  sq_t rt_nxt [SQ_STAGES];
  dv_t dvs_r [DIV_STAGES+1];
  dv_t dv_nxt [DIV_STAGES];
  dv_t dv0_nxt;
  sq_t sum_nxt;

  // Final colour stages.
  logic [15:0] k_r, k_nxt;
  logic [14:0] tr_r, tr_nxt;
  logic [17:0] tg_r, tg_nxt;
  logic [23:0] color_nxt;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cor_r <= '0;
      hor_r <= '0;
      ver_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CORNER: cor_r <= cfg_wdata;
        CFG_HORIZ:  hor_r <= cfg_wdata;
        CFG_VERT:   ver_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // A stage loads when it is empty or the stage above it moves on.
  always_comb begin
    en[NST-1] = !vld_r[NST-1] || !out_stall;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = !vld_r[i] || en[i+1];
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = vld_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_valid;
      for (int i = 1; i < NST; i++) begin
        if (en[i]) vld_r[i] <= vld_r[i-1];
      end
    end
  end

  // Border band test on the incoming coordinate.
  always_comb begin
    col_s = {2'b00, in_pixel_col};
    row_s = {2'b00, in_pixel_row};
    bord_nxt = (row_s < BW_S) || (row_s > H_LO_S && row_s < H_S) ||
               (col_s < BW_S) || (col_s > W_LO_S && col_s < W_S);
  end

  // Corrected fractions u, v and the clamped border gradient.
  always_comb begin
    logic [27:0] du, dv;
    logic [26:0] cx, cy, drr, dgg;
    logic [15:0] rq, gq;
    logic [7:0]  r8, g8;
    du = {col_c_r, 16'h0000} - uw_c_r;
    dv = {row_c_r, 16'h0000} - vw_c_r;
    u16_nxt = u0_c_r + 24'(du >= 28'(IMG_WIDTH));
    v16_nxt = v0_c_r + 24'(dv >= 28'(IMG_HEIGHT));
    cx  = 27'(col_c_r) * 27'(C_GAIN);
    cy  = 27'(row_c_r) * 27'(C_GAIN);
    drr = cx - rw_c_r;
    dgg = cy - gw_c_r;
    rq  = r0_c_r + 16'(drr >= 27'(BR_DIV));
    gq  = g0_c_r + 16'(dgg >= 27'(BG_DIV));
    r8  = (rq > 16'd255) ? 8'hFF : rq[7:0];
    g8  = (gq > 16'd255) ? 8'hFF : gq[7:0];
    side_nxt.border = bord_c_r;
    side_nxt.bcolor = {r8, g8, C_BORDER_B};
  end

  // Span products, direction components and their squares.
  always_comb begin
    logic signed [41:0] acc;
    logic signed [25:0] qs;
    logic signed [31:0] p;
    for (int i = 0; i < 3; i++) begin
      ph_nxt[i] = $signed(hor_r[16*i +: 16]) * $signed({1'b0, u16_r});
      pv_nxt[i] = $signed(ver_r[16*i +: 16]) * $signed({1'b0, v16_r});
      acc = $signed({cor_r[16*i +: 16], 16'h0000}) + ph_r[i] + pv_r[i];
      qs  = acc[41:16];
      if (qs > 26'sd32767) begin
        d_nxt[i] = 16'sh7FFF;
      end else if (qs < -26'sd32768) begin
        d_nxt[i] = 16'sh8000;
      end else begin
        d_nxt[i] = qs[15:0];
      end
      p = d_r[i] * d_r[i];
      sq_nxt[i] = p[30:0];
    end
    sum_nxt.rad  = 32'(sq_r[0]) + 32'(sq_r[1]) + 32'(sq_r[2]);
    sum_nxt.rem  = '0;
    sum_nxt.root = '0;
    sum_nxt.dy   = dy_r;
  end

  // Square root, two radicand bits per step.
  for (genvar j = 0; j < SQ_STAGES; j++) begin : g_sqrt
    always_comb begin
      sq_t         cur;
      logic [34:0] remt, trial;
      cur = sqs_r[j];
      for (int s = 0; s < SQ_PER; s++) begin
        remt  = {cur.rem[32:0], cur.rad[31:30]};
        trial = {1'b0, cur.root, 2'b01};
        if (remt >= trial) begin
          cur.rem  = remt - trial;
          cur.root = {cur.root[30:0], 1'b1};
        end else begin
          cur.rem  = remt;
          cur.root = {cur.root[30:0], 1'b0};
        end
        cur.rad = {cur.rad[29:0], 2'b00};
      end
      rt_nxt[j] = cur;
    end
  end

  // Dividend for k: dy scaled plus the length, floored at zero.
  always_comb begin
    logic [31:0]        n;
    logic signed [33:0] num;
    n   = sqs_r[SQ_STAGES].root;
    num = $signed({{2{sqs_r[SQ_STAGES].dy[15]}}, sqs_r[SQ_STAGES].dy, 16'h0000}) +
          $signed({2'b00, n});
    dv0_nxt.r  = num[33] ? 35'd0 : {1'b0, num};
    dv0_nxt.q  = '0;
    dv0_nxt.d2 = {n, 1'b0};
    dv0_nxt.nz = (n == 32'd0);
  end

  // Restoring divider, one quotient bit per step.
  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    always_comb begin
      dv_t  cur;
      logic ge;
      cur = dvs_r[j];
      for (int s = 0; s < DIV_PER; s++) begin
        if (j * DIV_PER + s < DIV_STEPS) begin
          ge = cur.r >= {2'b00, cur.d2};
          if (ge) cur.r = cur.r - {2'b00, cur.d2};
          cur.r = {cur.r[33:0], 1'b0};
          cur.q = {cur.q[15:0], ge};
        end
      end
      dv_nxt[j] = cur;
    end
  end

  // Sky shade: k, then the two channel scalings, then border or sky colour.
  always_comb begin
    logic [16:0] q;
    logic [17:0] dr;
    logic [19:0] dg;
    logic [32:0] xr;
    logic [33:0] xg;
    logic [27:0] rp;
    logic [36:0] gp;
    q = dvs_r[DIV_STAGES].q;
    if (dvs_r[DIV_STAGES].nz) begin
      k_nxt = 16'h8000;
    end else begin
      k_nxt = q[16] ? 16'hFFFF : q[15:0];
    end
    dr = 18'd131072 - {2'b00, k_r};
    dg = 20'd655360 - (20'(k_r) + {3'b000, k_r, 1'b0});
    xr = 33'(dr) * 33'(C_GAIN);
    xg = 34'(dg) * 34'(C_GAIN);
    tr_nxt = xr[31:17];
    tg_nxt = xg[33:16];
    rp = 28'(tr_r) * 28'(C_RECIP_R);
    gp = 37'(tg_r) * 37'(C_RECIP_G);
    color_nxt = side_r[ST_T].border ? side_r[ST_T].bcolor :
                {rp[26:19], gp[35:28], 8'hFF};
  end

  // Payload registers of every stage.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      col_a_r  <= in_pixel_col;
      row_a_r  <= in_pixel_row;
      bord_a_r <= bord_nxt;
      mu_a_r   <= 37'(in_pixel_col) * 37'(MU_C);
      mv_a_r   <= 37'(in_pixel_row) * 37'(MV_C);
      mr_a_r   <= 28'(in_pixel_col) * 28'(MBR_C);
      mg_a_r   <= 28'(in_pixel_row) * 28'(MBG_C);
    end
    if (en[1]) begin
      col_b_r  <= col_a_r;
      row_b_r  <= row_a_r;
      bord_b_r <= bord_a_r;
      u0_b_r   <= mu_a_r[35:12];
      v0_b_r   <= mv_a_r[35:12];
      r0_b_r   <= mr_a_r[27:12];
      g0_b_r   <= mg_a_r[27:12];
    end
    if (en[2]) begin
      col_c_r  <= col_b_r;
      row_c_r  <= row_b_r;
      bord_c_r <= bord_b_r;
      u0_c_r   <= u0_b_r;
      v0_c_r   <= v0_b_r;
      r0_c_r   <= r0_b_r;
      g0_c_r   <= g0_b_r;
      uw_c_r   <= 28'(u0_b_r) * 28'(IMG_WIDTH);
      vw_c_r   <= 28'(v0_b_r) * 28'(IMG_HEIGHT);
      rw_c_r   <= 27'(r0_b_r) * 27'(BR_DIV);
      gw_c_r   <= 27'(g0_b_r) * 27'(BG_DIV);
    end
    if (en[SIDE_FIRST]) begin
      u16_r <= u16_nxt;
      v16_r <= v16_nxt;
      side_r[SIDE_FIRST] <= side_nxt;
    end
    for (int i = SIDE_FIRST + 1; i <= ST_T; i++) begin
      if (en[i]) side_r[i] <= side_r[i-1];
    end
    if (en[ST_SPAN]) begin
      ph_r <= ph_nxt;
      pv_r <= pv_nxt;
    end
    if (en[ST_DIR]) d_r <= d_nxt;
    if (en[ST_SQR]) begin
      sq_r <= sq_nxt;
      dy_r <= d_r[1];
    end
    if (en[ST_SUM]) sqs_r[0] <= sum_nxt;
    for (int j = 0; j < SQ_STAGES; j++) begin
      if (en[ST_SUM+1+j]) sqs_r[j+1] <= rt_nxt[j];
    end
    if (en[ST_NUM]) dvs_r[0] <= dv0_nxt;
    for (int j = 0; j < DIV_STAGES; j++) begin
      if (en[ST_NUM+1+j]) dvs_r[j+1] <= dv_nxt[j];
    end
    if (en[ST_K]) k_r <= k_nxt;
    if (en[ST_T]) begin
      tr_r <= tr_nxt;
      tg_r <= tg_nxt;
    end
    if (en[ST_OUT]) begin
      out_pixel_color <= color_nxt;
      out_in_border   <= side_r[ST_T].border;
    end
  end

endmodule

### test/tb_sky_gradient_pixel_shader.sv
// Self-checking testbench for the sky gradient pixel shader.
`timescale 1ns / 1ps

module tb_sky_gradient_pixel_shader
  import sgps_pkg::*;
;

  localparam int W  = 1024;
  localparam int H  = 512;
  localparam int BW = 16;

  typedef struct packed {
    logic [11:0] col;
    logic [11:0] row;
  } pixel_t;

  typedef struct packed {
    logic [23:0] color;
    logic        border;
  } shade_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [11:0] in_pixel_col = '0;
  logic [11:0] in_pixel_row = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [23:0] out_pixel_color;
  logic        out_in_border;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [47:0] cfg_wdata = '0;

  // View vectors as the predictor sees them.
  logic [47:0] view_corner = '0;
  logic [47:0] view_horiz  = '0;
  logic [47:0] view_vert   = '0;

  pixel_t pixel_queue[$];
  shade_t shade_queue[$];
  int     fail_count = 0;
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  logic   word_taken = 1'b0;

  sky_gradient_pixel_shader i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_pixel_col(in_pixel_col), .in_pixel_row(in_pixel_row),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_pixel_color(out_pixel_color), .out_in_border(out_in_border),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Signed Q8.8 component of a packed view vector.
  function automatic longint view_comp(logic [47:0] vec, int idx);
    logic signed [15:0] c;
    c = vec[16*idx +: 16];
    return longint'(c);
  endfunction

  function automatic longint floor_q16(longint x);
    if (x >= 0) return x >>> 16;
    return -((-x + 65535) >>> 16);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint clamp_byte(longint v);
    if (v < 0) return 0;
    if (v > 255) return 255;
    return v;
  endfunction

  // Colour that one pixel should receive under the current view vectors.
  function automatic shade_t shade_pixel(pixel_t p);
    longint col, row, u16, v16, acc, q, k, num, r, g, b;
    longint d[3];
    longint unsigned sum, n;
    logic border;
    shade_t s;
    col = p.col;
    row = p.row;
    border = (row < BW) || (row > H - BW && row < H) ||
             (col < BW) || (col > W - BW && col < W);
    if (border) begin
      r = clamp_byte((25599 * col) / (100 * W));
      g = clamp_byte((25599 * row) / (100 * H));
      b = 51;
    end else begin
      u16 = (col * 65536) / W;
      v16 = (row * 65536) / H;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        acc = view_comp(view_corner, i) * 65536 + view_comp(view_horiz, i) * u16 +
              view_comp(view_vert, i) * v16;
        q = floor_q16(acc);
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        d[i] = q;
        sum = sum + longint'(q * q);
      end
      n = int_sqrt(sum << 32);
      // A zero-length ray counts as level.
      if (n == 0) begin
        k = 32768;
      end else begin
        num = d[1] * 65536 + longint'(n);
        if (num < 0) num = 0;
        k = (num * 32768) / longint'(n);
        if (k > 65535) k = 65535;
      end
      r = clamp_byte((25599 * (131072 - k)) / 13107200);
      g = clamp_byte((25599 * (655360 - 3 * k)) / 65536000);
      b = 255;
    end
    s.color = {r[7:0], g[7:0], b[7:0]};
    s.border = border;
    return s;
  endfunction

  // Input driver: pending words with random gaps; out_stall also random.
  always @(negedge clk) begin
    logic       nv;
    pixel_t     p;
    nv = in_valid;
    if (!in_valid || word_taken) begin
      nv = 1'b0;
      if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        p = pixel_queue.pop_front();
        in_pixel_col <= p.col;
        in_pixel_row <= p.row;
        nv = 1'b1;
      end
    end
    in_valid <= nv;
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Monitor: predicts on acceptance and checks each result word.
  always @(posedge clk) begin
    shade_t want;
    word_taken <= in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall)
      shade_queue.push_back(shade_pixel({in_pixel_col, in_pixel_row}));
    if (rst_n && out_valid && !out_stall) begin
      if (shade_queue.size() == 0) begin
        $error("result word with nothing expected");
        fail_count++;
      end else begin
        want = shade_queue.pop_front();
        if (out_pixel_color !== want.color) begin
          $error("pixel_color expected %06h actual %06h", want.color, out_pixel_color);
          fail_count++;
        end
        if (out_in_border !== want.border) begin
          $error("in_border expected %0b actual %0b", want.border, out_in_border);
          fail_count++;
        end
      end
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [47:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx == CFG_CORNER) view_corner = data;
    else if (idx == CFG_HORIZ) view_horiz = data;
    else if (idx == CFG_VERT) view_vert = data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_view(logic [47:0] c, logic [47:0] h, logic [47:0] v);
    write_reg(CFG_CORNER, c);
    write_reg(CFG_HORIZ, h);
    write_reg(CFG_VERT, v);
  endtask

  task automatic push_pixel(int col, int row);
    pixel_t p;
    p.col = 12'(col);
    p.row = 12'(row);
    pixel_queue.push_back(p);
  endtask

  task automatic push_random(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) < 7)
        push_pixel($urandom_range(W - 1), $urandom_range(H - 1));
      else
        push_pixel($urandom_range(4095), $urandom_range(4095));
    end
  endtask

  // Waits until every word has gone through and the pipeline has drained.
  task automatic drain();
    while (pixel_queue.size() != 0 || in_valid || shade_queue.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed words with the view vectors still at zero: level rays inside.
    push_pixel(0, 0);
    push_pixel(4095, 4095);
    push_pixel(15, 200);
    push_pixel(16, 200);
    push_pixel(1008, 200);
    push_pixel(1009, 200);
    push_pixel(1023, 200);
    push_pixel(1024, 200);
    push_pixel(500, 15);
    push_pixel(500, 16);
    push_pixel(500, 496);
    push_pixel(500, 497);
    push_pixel(500, 511);
    push_pixel(500, 512);
    push_pixel(2048, 4000);
    push_pixel(4095, 100);
    push_pixel(300, 4095);
    drain();

    // Typical camera: corner (-2,-1,-1), span (4,0,0) and (0,2,0).
    set_view({16'hFF00, 16'hFF00, 16'hFE00}, {16'h0, 16'h0, 16'h0400},
             {16'h0, 16'h0200, 16'h0});
    write_reg(cfg_idx_t'(2'd3), 48'({$urandom, $urandom}));
    push_pixel(512, 256);
    push_pixel(17, 17);
    push_pixel(1007, 495);
    push_pixel(3000, 3000);
    push_random(130);
    drain();

    // Largest positive components saturate the direction.
    send_idle_pct = 57;
    set_view({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}});
    push_random(130);
    drain();

    // Most negative components.
    send_idle_pct = 0;
    recv_stall_pct = 57;
    set_view({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}});
    push_random(130);
    drain();

    // Random view vectors.
    send_idle_pct = 9;
    recv_stall_pct = 9;
    set_view(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
             48'({$urandom, $urandom}));
    push_random(130);
    drain();

    send_idle_pct = 57;
    recv_stall_pct = 57;
    set_view(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
             48'({$urandom, $urandom}));
    push_random(130);
    drain();

    if (fail_count == 0)
      $display("sky_gradient_pixel_shader verification clean");
    else
      $display("sky_gradient_pixel_shader verification failed");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("sky_gradient_pixel_shader verification failed");
    $finish;
  end

endmodule

### sky_gradient_pixel_shader.f
rtl/sgps_pkg.sv
rtl/sky_gradient_pixel_shader.sv
test/tb_sky_gradient_pixel_shader.sv
